/* design/rldm_pkg.sv */
// Package for the RGB LED dimmer mode control unit.
// Holds widths, reset values, event and color codes, payload types and helpers.
// No dependencies; every design file refers to it by scoped names.
`default_nettype none

package rldm_pkg;

  // Knob converter resolution and derived widths
  localparam int SampleBits    = 12;
  localparam int DutyW         = 14;
  localparam int DeadbandW     = 12;
  localparam int ModeW         = 2;
  localparam int ColorW        = 2;
  localparam int NumColors     = 3;
  localparam int CompositeDiv  = 1024;
  localparam int CompositeShft = $clog2(CompositeDiv);
  localparam int ProdW         = 2 * SampleBits;

  localparam logic [DutyW-1:0]      DutyMax       = {DutyW{1'b1}};
  localparam logic [DeadbandW-1:0]  DeadbandReset = DeadbandW'(80);
  localparam logic [SampleBits-1:0] LevelReset    = SampleBits'(100);
  localparam logic [DutyW-1:0]      DutyReset     = DutyW'(100);

  // Stream payload widths, rounded up to whole bytes
  localparam int InTdataW  = ((SampleBits + 7) / 8) * 8;
  localparam int ResultW   = NumColors * DutyW + NumColors + 1 + ColorW;
  localparam int OutTdataW = ((ResultW + 7) / 8) * 8;

  // Register port
  localparam int ApbDataW = 32;
  localparam int CfgAddrW = 3;
  localparam int CfgIdxW  = CfgAddrW - 2;
  localparam logic [CfgIdxW-1:0] RegDeadband = CfgIdxW'(0);

  typedef enum logic [ModeW-1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_NEXT   = 2'd1,
    MODE_TOGGLE = 2'd2
  } mode_e;

  typedef enum logic [ColorW-1:0] {
    COLOR_RED   = 2'd0,
    COLOR_GREEN = 2'd1,
    COLOR_BLUE  = 2'd2
  } color_e;

  typedef struct packed {
    logic [ModeW-1:0]      mode;
    logic [SampleBits-1:0] sample;
  } item_t;

  // Declared MSB first so the packed image matches tdata, duty_red lowest
  typedef struct packed {
    logic [ColorW-1:0] selected_color;
    logic              in_composite;
    logic              enable_blue;
    logic              enable_green;
    logic              enable_red;
    logic [DutyW-1:0]  duty_blue;
    logic [DutyW-1:0]  duty_green;
    logic [DutyW-1:0]  duty_red;
  } result_t;

  function automatic logic outside_band(input logic [SampleBits-1:0] a,
                                        input logic [SampleBits-1:0] b,
                                        input logic [DeadbandW-1:0]  band);
    logic [SampleBits-1:0] diff;
    diff = (a > b) ? (a - b) : (b - a);
    return diff > band;
  endfunction

  function automatic color_e next_color(input color_e c);
    color_e n;
    unique case (c)
      COLOR_RED:   n = COLOR_GREEN;
      COLOR_GREEN: n = COLOR_BLUE;
      default:     n = COLOR_RED;
    endcase
    return n;
  endfunction

  function automatic logic [NumColors-1:0] only_color(input color_e c);
    logic [NumColors-1:0] en;
    unique case (c)
      COLOR_GREEN: en = 3'b010;
      COLOR_BLUE:  en = 3'b100;
      default:     en = 3'b001;
    endcase
    return en;
  endfunction

  // snapshot * sample / 1024, saturated to the duty range
  function automatic logic [DutyW-1:0] scale_duty(input logic [SampleBits-1:0] level,
                                                  input logic [SampleBits-1:0] smp);
    logic [ProdW-1:0] prod;
    logic [ProdW-1:0] quot;
    prod = ProdW'(level) * ProdW'(smp);
    quot = prod >> CompositeShft;
    return (quot > ProdW'(DutyMax)) ? DutyMax : DutyW'(quot);
  endfunction

endpackage

`default_nettype wire

/* design/rldm_cfg.sv */
// APB register port of the dimmer controller: holds the deadband register.
// Depends on rldm_pkg.
`default_nettype none

module rldm_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [rldm_pkg::CfgAddrW-1:0]    paddr,
  input  wire logic [rldm_pkg::ApbDataW-1:0]    pwdata,
  output      logic [rldm_pkg::ApbDataW-1:0]    prdata,
  output      logic                             pready,
  output      logic [rldm_pkg::DeadbandW-1:0]   deadband_o
);

  logic [rldm_pkg::DeadbandW-1:0] deadband_q;
  logic [rldm_pkg::CfgIdxW-1:0]   reg_idx;
  logic                           wr_en;

  assign reg_idx = paddr[rldm_pkg::CfgAddrW-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= rldm_pkg::DeadbandReset;
    end else if (wr_en && (reg_idx == rldm_pkg::RegDeadband)) begin
      deadband_q <= pwdata[rldm_pkg::DeadbandW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == rldm_pkg::RegDeadband) begin
      prdata = rldm_pkg::ApbDataW'(deadband_q);
    end
  end

  assign deadband_o = deadband_q;

endmodule

`default_nettype wire

/* design/rldm_in_reg.sv */
// Input register of the dimmer controller: captures one event request.
// Depends on rldm_pkg.
`default_nettype none

module rldm_in_reg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  input  wire logic [rldm_pkg::InTdataW-1:0]  s_axis_tdata,
  input  wire logic [rldm_pkg::ModeW-1:0]     s_axis_tuser,
  input  wire logic                           take_i,
  output      logic                           valid_o,
  output      rldm_pkg::item_t                item_o
);

  logic            valid_q;
  rldm_pkg::item_t item_q;

  // Refill in the same cycle the held request moves on
  assign s_axis_tready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.mode   <= s_axis_tuser;
      item_q.sample <= s_axis_tdata[rldm_pkg::SampleBits-1:0];
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* design/rldm_core.sv */
// Mode and level state of the dimmer controller with its per-event update logic.
// Depends on rldm_pkg.
`default_nettype none

module rldm_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            step_i,
  input  wire rldm_pkg::item_t                 item_i,
  input  wire logic [rldm_pkg::DeadbandW-1:0]  deadband_i,
  output      rldm_pkg::result_t               result_o
);

  localparam int N  = rldm_pkg::NumColors;
  localparam int SB = rldm_pkg::SampleBits;
  localparam int DW = rldm_pkg::DutyW;

  logic                 composite_q, composite_d;
  rldm_pkg::color_e     color_q, color_d;
  logic [SB-1:0]        level_q [N];
  logic [SB-1:0]        level_d [N];
  logic [SB-1:0]        snap_q  [N];
  logic [SB-1:0]        snap_d  [N];
  logic [SB-1:0]        ref_q, ref_d;
  logic [SB-1:0]        latest_q, latest_d;
  logic [DW-1:0]        duty_q  [N];
  logic [DW-1:0]        duty_d  [N];
  logic [N-1:0]         en_q, en_d;

  logic [SB-1:0]        smp;
  logic [SB-1:0]        sel_level;
  logic                 ref_moved;
  logic [DW-1:0]        scaled [N];

  assign smp       = item_i.sample;
  assign sel_level = level_q[color_q];
  assign ref_moved = rldm_pkg::outside_band(smp, ref_q, deadband_i);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      scaled[i] = rldm_pkg::scale_duty(snap_q[i], smp);
    end
  end

  always_comb begin
    composite_d = composite_q;
    color_d     = color_q;
    level_d     = level_q;
    snap_d      = snap_q;
    ref_d       = ref_q;
    latest_d    = latest_q;
    duty_d      = duty_q;
    en_d        = en_q;
    if (!composite_q) begin
      unique case (item_i.mode)
        rldm_pkg::MODE_SAMPLE: begin
          latest_d = smp;
          if (ref_moved && rldm_pkg::outside_band(smp, sel_level, deadband_i)) begin
            level_d[color_q] = smp;
            duty_d[color_q]  = DW'(smp);
            ref_d            = smp;
          end
        end
        rldm_pkg::MODE_NEXT: begin
          color_d = rldm_pkg::next_color(color_q);
          en_d    = rldm_pkg::only_color(color_d);
        end
        rldm_pkg::MODE_TOGGLE: begin
          snap_d      = level_q;
          en_d        = '1;
          ref_d       = latest_q;
          color_d     = rldm_pkg::COLOR_RED;
          composite_d = 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      unique case (item_i.mode)
        rldm_pkg::MODE_SAMPLE: begin
          if (ref_moved) begin
            for (int i = 0; i < N; i++) begin
              duty_d[i] = scaled[i];
              en_d[i]   = (scaled[i] != '0);
            end
            ref_d = smp;
          end
        end
        rldm_pkg::MODE_TOGGLE: begin
          level_d     = snap_q;
          composite_d = 1'b0;
          color_d     = rldm_pkg::COLOR_RED;
          en_d        = rldm_pkg::only_color(rldm_pkg::COLOR_RED);
        end
        default: begin
          // next-color is ignored while scaling all channels
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      composite_q <= 1'b0;
      color_q     <= rldm_pkg::COLOR_RED;
      ref_q       <= '0;
      latest_q    <= '0;
      en_q        <= rldm_pkg::only_color(rldm_pkg::COLOR_RED);
      for (int i = 0; i < N; i++) begin
        level_q[i] <= rldm_pkg::LevelReset;
        snap_q[i]  <= rldm_pkg::LevelReset;
        duty_q[i]  <= rldm_pkg::DutyReset;
      end
    end else if (step_i) begin
      composite_q <= composite_d;
      color_q     <= color_d;
      ref_q       <= ref_d;
      latest_q    <= latest_d;
      en_q        <= en_d;
      level_q     <= level_d;
      snap_q      <= snap_d;
      duty_q      <= duty_d;
    end
  end

  // Result shows the state after this event
  always_comb begin
    result_o.duty_red       = duty_d[0];
    result_o.duty_green     = duty_d[1];
    result_o.duty_blue      = duty_d[2];
    result_o.enable_red     = en_d[0];
    result_o.enable_green   = en_d[1];
    result_o.enable_blue    = en_d[2];
    result_o.in_composite   = composite_d;
    result_o.selected_color = composite_d ? rldm_pkg::COLOR_RED : color_d;
  end

endmodule

`default_nettype wire

/* design/rldm_out_reg.sv */
// Result register of the dimmer controller: holds one result until taken.
// Depends on rldm_pkg.
`default_nettype none

module rldm_out_reg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            load_i,
  input  wire rldm_pkg::result_t               result_i,
  output      logic                            space_o,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output      logic [rldm_pkg::OutTdataW-1:0]  m_axis_tdata
);

  logic              valid_q;
  rldm_pkg::result_t result_q;

  assign space_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = rldm_pkg::OutTdataW'(result_q);

endmodule

`default_nettype wire

/* design/rgb_led_dimmer_mode_control_unit.sv */
// RGB LED dimmer mode control unit, top level.
// Depends on rldm_pkg, rldm_cfg, rldm_in_reg, rldm_core, rldm_out_reg.
//
// Usage:
// - Event requests enter on the s_axis channel: tuser carries the event kind
//   (knob sample, next-color press, composite toggle), tdata the knob sample.
// - Each request yields exactly one result on m_axis: three PWM duties, three
//   output enables, the composite flag and the selected color.
// - The deadband register sits at byte address 0 of the APB port; write it
//   only while no request is in flight.
// - Timing: an accepted request waits in the input register; when it advances,
//   the state update and result register load happen together, putting the
//   result on m_axis.
// - Throughput: one request per cycle while m_axis is not stalled; the state
//   update loop closes through the input and result registers.
// - Receiver stall: the held result stays on m_axis; one further request is
//   still taken into the input register, after which s_axis_tready drops.
// - Reset: adjust mode, red selected and enabled alone, all levels and duties
//   at 100, reference and last samples at 0, deadband at 80, both stages empty.
`default_nettype none

module rgb_led_dimmer_mode_control_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // tdata: sample [11:0], zero pad [15:12]
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  input  wire logic [rldm_pkg::InTdataW-1:0]    s_axis_tdata,
  // tuser: mode [1:0]
  input  wire logic [rldm_pkg::ModeW-1:0]       s_axis_tuser,
  // tdata: duty_red [13:0], duty_green [27:14], duty_blue [41:28],
  //        enable_red [42], enable_green [43], enable_blue [44],
  //        in_composite [45], selected_color [47:46]
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output      logic [rldm_pkg::OutTdataW-1:0]   m_axis_tdata,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [rldm_pkg::CfgAddrW-1:0]    paddr,
  input  wire logic [rldm_pkg::ApbDataW-1:0]    pwdata,
  output      logic [rldm_pkg::ApbDataW-1:0]    prdata,
  output      logic                             pready
);

  logic [rldm_pkg::DeadbandW-1:0] deadband;
  logic                           in_valid;
  rldm_pkg::item_t                item;
  rldm_pkg::result_t              result;
  logic                           out_space;
  logic                           step;

  // Advance a held request when the result register can take its result
  assign step = in_valid && out_space;

  rldm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .deadband_o (deadband)
  );

  rldm_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take_i        (step),
    .valid_o       (in_valid),
    .item_o        (item)
  );

  rldm_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (item),
    .deadband_i (deadband),
    .result_o   (result)
  );

  rldm_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (step),
    .result_i      (result),
    .space_o       (out_space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

/* design/rldm_checker.sv */
// Port-level checks for the RGB LED dimmer mode control unit, bound to the top.
// Depends on rldm_pkg and rgb_led_dimmer_mode_control_unit.
`default_nettype none

module rldm_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [rldm_pkg::OutTdataW-1:0]  m_axis_tdata
);

  rldm_pkg::result_t res;
  assign res = rldm_pkg::result_t'(m_axis_tdata[rldm_pkg::ResultW-1:0]);

  // Hold a stalled result
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // Selected color reads as red while scaling all channels
  a_composite_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.in_composite |-> res.selected_color == rldm_pkg::COLOR_RED)
    else $error("selected color nonzero in composite mode");

  // Adjust mode drives exactly one channel, the selected one
  a_adjust_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.in_composite |->
      $onehot({res.enable_blue, res.enable_green, res.enable_red}) &&
      (res.enable_red   == (res.selected_color == rldm_pkg::COLOR_RED)) &&
      (res.enable_green == (res.selected_color == rldm_pkg::COLOR_GREEN)))
    else $error("adjust mode enables do not match selected color");

  // Pad bits above the result stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata >> rldm_pkg::ResultW) == '0)
    else $error("tdata pad bits set");

endmodule

bind rgb_led_dimmer_mode_control_unit rldm_checker u_rldm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
